/* hdl/tcrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrf_pkg
// Shared types and constants of the character cell rectangle fill engine.
// ----------------------------------------------------------------------------
package tcrf_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int DIM_W    = 9;
  localparam int SPAN_W   = DIM_W + 2;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int COLOR_W  = 5;
  localparam int COUNT_W  = 14;
  localparam int CWIDTH_W = 8;
  localparam int CHEIGHT_W = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CWIDTH_W-1:0]  CANVAS_WIDTH_RST  = 8'd80;
  localparam logic [CHEIGHT_W-1:0] CANVAS_HEIGHT_RST = 7'd25;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CELL_W-1:0]  BLANK_CELL = 16'h0020;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 14'h3FFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLIP,
    ST_EVAL,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } tcrf_state_e;

  typedef struct packed {
    logic capture;
    logic clip;
    logic eval;
    logic walk;
    logic clear;
    logic load_out;
  } tcrf_ctrl_t;

  typedef struct packed {
    logic is_read;
    logic fill_hit;
    logic walk_last;
    logic clear_last;
  } tcrf_status_t;

endpackage

/* hdl/tcrf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrf_req_if / tcrf_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcrf_req_if;
  import tcrf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [DIM_W-1:0]   rect_x;
  logic signed [DIM_W-1:0]   rect_y;
  logic [DIM_W-1:0]          rect_w;
  logic [DIM_W-1:0]          rect_h;
  logic [CHAR_W-1:0]         fill_char;
  logic [COLOR_W-1:0]        fg_color;
  logic [COLOR_W-1:0]        bg_color;

  modport source (
    output valid, cmd, rect_x, rect_y, rect_w, rect_h, fill_char, fg_color, bg_color,
    input  ready
  );

  modport sink (
    input  valid, cmd, rect_x, rect_y, rect_w, rect_h, fill_char, fg_color, bg_color,
    output ready
  );
endinterface

interface tcrf_rsp_if;
  import tcrf_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   read_char;
  logic [ATTR_W-1:0]   read_attr;
  logic [COUNT_W-1:0]  cells_written;
  logic                in_range;

  modport source (
    output valid, read_char, read_attr, cells_written, in_range,
    input  ready
  );

  modport sink (
    input  valid, read_char, read_attr, cells_written, in_range,
    output ready
  );
endinterface

/* hdl/tcrf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrf_ctrl
// Sequencer: clearing pass, clipping, cell walk and response hand-off.
// ----------------------------------------------------------------------------
module tcrf_ctrl
  import tcrf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  input  tcrf_status_t status_i,
  output tcrf_ctrl_t   ctrl_o
);

  tcrf_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_CLIP;
        end
      end
      ST_CLIP: begin
        ctrl_o.clip = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        ctrl_o.eval = 1'b1;
        if (!status_i.is_read && status_i.fill_hit) begin
          state_d = ST_WALK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WALK: begin
        ctrl_o.walk = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/tcrf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrf_dp
// Datapath: canvas registers, clip logic, cell walker, cell memory and
// response register.
// ----------------------------------------------------------------------------
module tcrf_dp
  import tcrf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  tcrf_ctrl_t              ctrl_i,
  output tcrf_status_t            status_o,
  input  logic                    cmd_i,
  input  logic [DIM_W-1:0]        rect_x_i,
  input  logic [DIM_W-1:0]        rect_y_i,
  input  logic [DIM_W-1:0]        rect_w_i,
  input  logic [DIM_W-1:0]        rect_h_i,
  input  logic [CHAR_W-1:0]       fill_char_i,
  input  logic [COLOR_W-1:0]      fg_color_i,
  input  logic [COLOR_W-1:0]      bg_color_i,
  output logic [CHAR_W-1:0]       read_char_o,
  output logic [ATTR_W-1:0]       read_attr_o,
  output logic [COUNT_W-1:0]      cells_written_o,
  output logic                    in_range_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PROD_W = 2 * DIM_W;

  function automatic logic [CELL_W-1:0] blend_cell(
    input logic [CELL_W-1:0]  old,
    input logic [CHAR_W-1:0]  ch,
    input logic [COLOR_W-1:0] fg,
    input logic [COLOR_W-1:0] bg
  );
    logic [3:0] hi;
    logic [3:0] lo;
    hi = bg[COLOR_W-1] ? old[CELL_W-1 -: 4] : bg[3:0];
    lo = fg[COLOR_W-1] ? old[CHAR_W +: 4]   : fg[3:0];
    return {hi, lo, ch};
  endfunction

  // canvas size registers
  logic [CWIDTH_W-1:0]  cwidth_q;
  logic [CHEIGHT_W-1:0] cheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cwidth_q  <= CANVAS_WIDTH_RST;
      cheight_q <= CANVAS_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CANVAS_WIDTH:  cwidth_q  <= cfg_data_i[CWIDTH_W-1:0];
        REG_CANVAS_HEIGHT: cheight_q <= cfg_data_i[CHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic                cmd_q;
  logic [DIM_W-1:0]    x_q, y_q, w_q, h_q;
  logic [CHAR_W-1:0]   ch_q;
  logic [COLOR_W-1:0]  fg_q, bg_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_i;
      x_q   <= rect_x_i;
      y_q   <= rect_y_i;
      w_q   <= rect_w_i;
      h_q   <= rect_h_i;
      ch_q  <= fill_char_i;
      fg_q  <= fg_color_i;
      bg_q  <= bg_color_i;
    end
  end

  // clipping
  logic [DIM_W-1:0]         cw, chh;
  logic signed [SPAN_W-1:0] x_s, y_s, xe_s, ye_s, cw_s, ch_s;
  logic signed [SPAN_W-1:0] x0_s, y0_s, x1_s, y1_s, dx_s, dy_s, xl_s, yl_s;
  logic                     ne, hit;
  logic [ADDR_W-1:0]        raddr;

  always_comb begin
    cw   = ({1'b0, cwidth_q} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : {1'b0, cwidth_q};
    chh  = ({2'b00, cheight_q} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                     : {2'b00, cheight_q};
    x_s  = $signed({{2{x_q[DIM_W-1]}}, x_q});
    y_s  = $signed({{2{y_q[DIM_W-1]}}, y_q});
    cw_s = $signed({2'b00, cw});
    ch_s = $signed({2'b00, chh});
    xe_s = x_s + $signed({2'b00, w_q});
    ye_s = y_s + $signed({2'b00, h_q});
    x0_s = x_s[SPAN_W-1] ? '0 : x_s;
    y0_s = y_s[SPAN_W-1] ? '0 : y_s;
    x1_s = (xe_s > cw_s) ? cw_s : xe_s;
    y1_s = (ye_s > ch_s) ? ch_s : ye_s;
    dx_s = x1_s - x0_s;
    dy_s = y1_s - y0_s;
    xl_s = x1_s - SPAN_W'(1);
    yl_s = y1_s - SPAN_W'(1);
    ne   = (x1_s > x0_s) && (y1_s > y0_s);
    hit  = !x_s[SPAN_W-1] && (x_s < cw_s) && !y_s[SPAN_W-1] && (y_s < ch_s);
    raddr = ADDR_W'(COL_W'(x_q)) + ADDR_W'(ROW_W'(y_q)) * ADDR_W'(MAX_WIDTH);
  end

  logic [COL_W-1:0]  x0_q, xl_q;
  logic [ROW_W-1:0]  y0_q, yl_q;
  logic [DIM_W-1:0]  dx_q, dy_q;
  logic              ne_q, hit_q;
  logic [ADDR_W-1:0] raddr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clip) begin
      x0_q    <= COL_W'(x0_s);
      xl_q    <= COL_W'(xl_s);
      y0_q    <= ROW_W'(y0_s);
      yl_q    <= ROW_W'(yl_s);
      dx_q    <= DIM_W'(dx_s);
      dy_q    <= DIM_W'(dy_s);
      ne_q    <= ne;
      hit_q   <= hit;
      raddr_q <= raddr;
    end
  end

  // cell count
  logic [PROD_W-1:0]  prod;
  logic [COUNT_W-1:0] count_q;

  assign prod = PROD_W'(dx_q) * PROD_W'(dy_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      count_q <= (prod > PROD_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(prod);
    end
  end

  // walker
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [ADDR_W-1:0] base_q;
  logic              col_last, row_last;

  assign col_last = (col_q == xl_q);
  assign row_last = (row_q == yl_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      col_q  <= x0_q;
      row_q  <= y0_q;
      base_q <= ADDR_W'(y0_q) * ADDR_W'(MAX_WIDTH);
    end else if (ctrl_i.walk) begin
      if (col_last) begin
        col_q  <= x0_q;
        row_q  <= row_q + ROW_W'(1);
        base_q <= base_q + ADDR_W'(MAX_WIDTH);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // clearing pass counter and pending write
  logic [ADDR_W-1:0] clr_q;
  logic              wr_pend_q;
  logic [ADDR_W-1:0] wr_addr_q;
  logic [ADDR_W-1:0] walk_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  assign walk_addr = base_q + ADDR_W'(col_q);
  assign rd_addr   = ctrl_i.walk ? walk_addr : raddr_q;
  assign rd_en     = ctrl_i.walk || (ctrl_i.eval && (cmd_q == CMD_READ));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= ctrl_i.walk;
      if (ctrl_i.clear) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.walk) begin
      wr_addr_q <= walk_addr;
    end
  end

  // cell memory
  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      mem_q[clr_q] <= BLANK_CELL;
    end else if (wr_pend_q) begin
      mem_q[wr_addr_q] <= blend_cell(rdata_q, ch_q, fg_q, bg_q);
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      if (cmd_q == CMD_READ) begin
        read_char_o     <= hit_q ? rdata_q[CHAR_W-1:0] : '0;
        read_attr_o     <= hit_q ? rdata_q[CELL_W-1:CHAR_W] : '0;
        cells_written_o <= '0;
        in_range_o      <= hit_q;
      end else begin
        read_char_o     <= '0;
        read_attr_o     <= '0;
        cells_written_o <= ne_q ? count_q : '0;
        in_range_o      <= ne_q;
      end
    end
  end

  assign status_o.is_read    = (cmd_q == CMD_READ);
  assign status_o.fill_hit   = ne_q;
  assign status_o.walk_last  = col_last && row_last;
  assign status_o.clear_last = (clr_q == ADDR_W'(DEPTH - 1));

endmodule

/* hdl/text_cell_rect_fill_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_rect_fill_core
// Character cell framebuffer: clipped rectangle fill with transparent
// colours, and single cell read.
//
//   channel  direction  handshake      payload
//   req_i    in         valid/ready    cmd, rect_x/y/w/h, fill_char, colours
//   rsp_o    out        valid/ready    read_char, read_attr, cells_written,
//                                      in_range
//   cfg      in         cfg_we_i       cfg_idx_i, cfg_data_i
//
// a read passes the capture, clip and evaluate states before the response register loads
// a fill that covers cells walks them row by row, reading each cell and writing
// it back blended into the cell memory; an empty fill skips the walk
// after reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells runs with
// req_i.ready low; configuration writes are taken throughout
// a held response stalls the next one only at its hand-off
// ----------------------------------------------------------------------------
module text_cell_rect_fill_core
  import tcrf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tcrf_req_if.sink              req_i,
  tcrf_rsp_if.source            rsp_o
);

  tcrf_ctrl_t   ctrl;
  tcrf_status_t status;

  tcrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  tcrf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .cmd_i           (req_i.cmd),
    .rect_x_i        (req_i.rect_x),
    .rect_y_i        (req_i.rect_y),
    .rect_w_i        (req_i.rect_w),
    .rect_h_i        (req_i.rect_h),
    .fill_char_i     (req_i.fill_char),
    .fg_color_i      (req_i.fg_color),
    .bg_color_i      (req_i.bg_color),
    .read_char_o     (rsp_o.read_char),
    .read_attr_o     (rsp_o.read_attr),
    .cells_written_o (rsp_o.cells_written),
    .in_range_o      (rsp_o.in_range)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the character cell rectangle fill engine. A shadow
// cell store is updated on every accepted request and a canvas size on every
// register write; responses are checked field by field, oldest awaited first.
// Directed requests cover blank reads, clipping, transparent colours and
// empty fills; canvas sizes are swept through their extremes, and random
// traffic runs with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import tcrf_pkg::*;

  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 60;

  typedef struct packed {
    logic               cmd;
    logic [DIM_W-1:0]   rect_x;
    logic [DIM_W-1:0]   rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic [CHAR_W-1:0]  fill_char;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cell_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic [ATTR_W-1:0]  read_attr;
    logic [COUNT_W-1:0] cells_written;
    logic               in_range;
  } cell_rsp_t;

  bit                    clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tcrf_req_if req_bus ();
  tcrf_rsp_if rsp_bus ();

  text_cell_rect_fill_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  logic [CELL_W-1:0]    cell_mem [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  logic [CWIDTH_W-1:0]  canvas_w;
  logic [CHEIGHT_W-1:0] canvas_h;
  cell_rsp_t            cell_rsp_q [$];
  cell_rsp_t            rsp_want;

  bit idle_enable;
  int rsp_stall;
  int cycle_count;
  int mismatches;
  int reads_issued;
  int fills_issued;
  int cells_filled;
  int canvas_writes;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_width();
    return (int'(canvas_w) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(canvas_w);
  endfunction

  function automatic int eff_height();
    return (int'(canvas_h) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(canvas_h);
  endfunction

  // updates the shadow store and returns the response this request causes
  function automatic cell_rsp_t run_cell_command(input cell_cmd_t c);
    int x, y, cw, chh, x0, y0, x1, y1, n, a;
    logic [ATTR_W-1:0] attr;
    logic [3:0] hi, lo;
    cell_rsp_t r;
    r   = '0;
    x   = $signed(c.rect_x);
    y   = $signed(c.rect_y);
    cw  = eff_width();
    chh = eff_height();
    if (c.cmd == CMD_READ) begin
      reads_issued++;
      if (x >= 0 && x < cw && y >= 0 && y < chh) begin
        a = y * MAX_WIDTH_DEF + x;
        r.read_char = cell_mem[a][CHAR_W-1:0];
        r.read_attr = cell_mem[a][CELL_W-1:CHAR_W];
        r.in_range  = 1'b1;
      end
    end else begin
      fills_issued++;
      x0 = (x < 0) ? 0 : x;
      y0 = (y < 0) ? 0 : y;
      x1 = x + int'(c.rect_w);
      y1 = y + int'(c.rect_h);
      if (x1 > cw) x1 = cw;
      if (y1 > chh) y1 = chh;
      if (x1 > x0 && y1 > y0) begin
        n = (x1 - x0) * (y1 - y0);
        for (int row = y0; row < y1; row++) begin
          for (int col = x0; col < x1; col++) begin
            a    = row * MAX_WIDTH_DEF + col;
            attr = cell_mem[a][CELL_W-1:CHAR_W];
            hi   = (c.bg_color >= 16) ? attr[7:4] : c.bg_color[3:0];
            lo   = (c.fg_color >= 16) ? attr[3:0] : c.fg_color[3:0];
            cell_mem[a] = {hi, lo, c.fill_char};
          end
        end
        r.cells_written = (n > int'(COUNT_MAX)) ? COUNT_MAX : n[COUNT_W-1:0];
        r.in_range      = 1'b1;
        cells_filled += n;
      end
    end
    return r;
  endfunction

  function automatic cell_cmd_t fill_cmd(input int x, input int y, input int w, input int h,
                                         input int ch, input int fg, input int bg);
    cell_cmd_t c;
    c.cmd       = CMD_FILL;
    c.rect_x    = x[DIM_W-1:0];
    c.rect_y    = y[DIM_W-1:0];
    c.rect_w    = w[DIM_W-1:0];
    c.rect_h    = h[DIM_W-1:0];
    c.fill_char = ch[CHAR_W-1:0];
    c.fg_color  = fg[COLOR_W-1:0];
    c.bg_color  = bg[COLOR_W-1:0];
    return c;
  endfunction

  function automatic cell_cmd_t read_cmd(input int x, input int y);
    cell_cmd_t c;
    c     = fill_cmd(x, y, 0, 0, 0, 0, 0);
    c.cmd = CMD_READ;
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] random_colour();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return COLOR_W'($urandom_range(0, 15));
    if (pick == 7) return 5'd16;
    return COLOR_W'($urandom_range(17, 31));
  endfunction

  // mostly small fills and reads near the canvas, some long strips and a
  // few unrestricted rectangles
  function automatic cell_cmd_t random_cell_command();
    int cw, chh, pick, x, y;
    cell_cmd_t c;
    cw          = eff_width();
    chh         = eff_height();
    pick        = $urandom_range(0, 99);
    c.cmd       = CMD_FILL;
    c.fill_char = CHAR_W'($urandom_range(0, 255));
    c.fg_color  = random_colour();
    c.bg_color  = random_colour();
    c.rect_w    = DIM_W'($urandom_range(0, 6));
    c.rect_h    = DIM_W'($urandom_range(0, 6));
    x           = $urandom_range(0, cw + 6);
    y           = $urandom_range(0, chh + 6);
    c.rect_x    = DIM_W'(x - 4);
    c.rect_y    = DIM_W'(y - 4);
    if (pick < 35) begin
      c.cmd = CMD_READ;
      x = $urandom_range(0, cw + 1);
      y = $urandom_range(0, chh + 1);
      c.rect_x = DIM_W'(x - 1);
      c.rect_y = DIM_W'(y - 1);
      if (pick < 4) begin
        c.rect_x = DIM_W'($urandom_range(0, 511));
        c.rect_y = DIM_W'($urandom_range(0, 511));
      end
    end else if (pick < 87) begin
    end else if (pick < 93) begin
      c.rect_x = DIM_W'($urandom_range(0, 511));
      c.rect_w = DIM_W'($urandom_range(0, 511));
      c.rect_h = DIM_W'($urandom_range(0, 2));
    end else if (pick < 98) begin
      c.rect_y = DIM_W'($urandom_range(0, 511));
      c.rect_h = DIM_W'($urandom_range(0, 511));
      c.rect_w = DIM_W'($urandom_range(0, 2));
    end else begin
      c.rect_x = DIM_W'($urandom_range(0, 511));
      c.rect_y = DIM_W'($urandom_range(0, 511));
      c.rect_w = DIM_W'($urandom_range(0, 511));
      c.rect_h = DIM_W'($urandom_range(0, 511));
    end
    return c;
  endfunction

  task automatic send_cell_command(input cell_cmd_t c);
    @(negedge clk_i);
    req_bus.valid     = 1'b1;
    req_bus.cmd       = c.cmd;
    req_bus.rect_x    = c.rect_x;
    req_bus.rect_y    = c.rect_y;
    req_bus.rect_w    = c.rect_w;
    req_bus.rect_h    = c.rect_h;
    req_bus.fill_char = c.fill_char;
    req_bus.fg_color  = c.fg_color;
    req_bus.bg_color  = c.bg_color;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    cell_rsp_q.push_back(run_cell_command(c));
  endtask

  task automatic release_request();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
  endtask

  task automatic pause_sender();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      release_request();
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_responses();
    release_request();
    while (cell_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_canvas_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_CANVAS_WIDTH) canvas_w = value;
    else canvas_h = value[CHEIGHT_W-1:0];
    canvas_writes++;
  endtask

  task automatic set_canvas(input int w, input int h);
    wait_for_responses();
    write_canvas_reg(REG_CANVAS_WIDTH, w[CFG_DATA_W-1:0]);
    write_canvas_reg(REG_CANVAS_HEIGHT, h[CFG_DATA_W-1:0]);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic test_blank_reads();
    send_cell_command(read_cmd(0, 0));
    send_cell_command(read_cmd(79, 24));
    send_cell_command(read_cmd(80, 0));
    send_cell_command(read_cmd(0, 25));
    send_cell_command(read_cmd(-1, -1));
    send_cell_command(read_cmd(-256, 255));
  endtask

  task automatic test_fill_cases();
    // single cell draw, then both colours transparent over the whole canvas
    send_cell_command(fill_cmd(0, 0, 1, 1, 8'h41, 15, 15));
    send_cell_command(read_cmd(0, 0));
    send_cell_command(fill_cmd(-256, -256, 511, 511, 8'hFF, 16, 31));
    // clear with a space and foreground 0
    send_cell_command(fill_cmd(10, 5, 20, 10, 8'h20, 0, 3));
    send_cell_command(fill_cmd(12, 6, 4, 4, 8'h00, 17, 9));
    send_cell_command(fill_cmd(13, 7, 2, 2, 8'h7E, 5, 16));
    // empty and fully clipped rectangles
    send_cell_command(fill_cmd(5, 5, 0, 5, 8'h31, 1, 1));
    send_cell_command(fill_cmd(5, 5, 5, 0, 8'h32, 2, 2));
    send_cell_command(fill_cmd(-10, 0, 10, 3, 8'h33, 3, 3));
    send_cell_command(fill_cmd(80, 0, 5, 3, 8'h34, 4, 4));
    // partial clips and widest and tallest spans
    send_cell_command(fill_cmd(-3, -2, 6, 4, 8'h35, 6, 7));
    send_cell_command(fill_cmd(-256, 3, 511, 1, 8'h36, 8, 16));
    send_cell_command(fill_cmd(40, -256, 1, 511, 8'h37, 16, 10));
    send_cell_command(read_cmd(13, 7));
    send_cell_command(read_cmd(12, 6));
    send_cell_command(read_cmd(79, 24));
    send_cell_command(read_cmd(1, 0));
    send_cell_command(read_cmd(40, 3));
  endtask

  task automatic test_canvas_limits();
    set_canvas(128, 64);
    send_cell_command(fill_cmd(-1, -1, 300, 300, 8'h55, 1, 2));
    send_cell_command(read_cmd(127, 63));
    send_cell_command(read_cmd(128, 0));
    // sizes above the store saturate
    set_canvas(255, 127);
    send_cell_command(read_cmd(127, 63));
    send_cell_command(read_cmd(200, 0));
    send_cell_command(fill_cmd(100, 50, 100, 100, 8'hAA, 16, 12));
    set_canvas(0, 0);
    send_cell_command(read_cmd(0, 0));
    send_cell_command(fill_cmd(0, 0, 5, 5, 8'h11, 3, 3));
    set_canvas(80, 200);
    send_cell_command(read_cmd(0, 63));
    // contents are kept when the canvas shrinks and grows again
    set_canvas(80, 25);
    send_cell_command(read_cmd(100, 30));
    set_canvas(128, 64);
    send_cell_command(read_cmd(100, 30));
  endtask

  task automatic test_random_traffic();
    int phase_w [7] = '{80, 40, 128, 1, 255, 17, 80};
    int phase_h [7] = '{25, 10, 64, 1, 127, 3, 25};
    for (int p = 0; p < 7; p++) begin
      set_canvas(phase_w[p], phase_h[p]);
      idle_enable = (p != 6);
      repeat (PHASE_ITEMS) begin
        pause_sender();
        send_cell_command(random_cell_command());
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rsp_stall > 0) begin
      rsp_bus.ready = 1'b0;
      rsp_stall--;
    end else begin
      rsp_bus.ready = 1'b1;
      if (idle_enable && $urandom_range(0, 5) == 0) rsp_stall = $urandom_range(1, 5);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (cell_rsp_q.size() == 0) begin
        $display("%0t: response with no request outstanding, expected none actual %0d/%0d",
                 $time, rsp_bus.cells_written, rsp_bus.in_range);
        mismatches++;
      end else begin
        rsp_want = cell_rsp_q.pop_front();
        check_field("read_char", rsp_want.read_char, rsp_bus.read_char);
        check_field("read_attr", rsp_want.read_attr, rsp_bus.read_attr);
        check_field("cells_written", rsp_want.cells_written, rsp_bus.cells_written);
        check_field("in_range", rsp_want.in_range, rsp_bus.in_range);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d responses outstanding",
               $time, cell_rsp_q.size());
      $display("FAIL text_cell_rect_fill_core");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    req_bus.valid     = 1'b0;
    req_bus.cmd       = CMD_FILL;
    req_bus.rect_x    = '0;
    req_bus.rect_y    = '0;
    req_bus.rect_w    = '0;
    req_bus.rect_h    = '0;
    req_bus.fill_char = '0;
    req_bus.fg_color  = '0;
    req_bus.bg_color  = '0;
    canvas_w          = CANVAS_WIDTH_RST;
    canvas_h          = CANVAS_HEIGHT_RST;
    idle_enable       = 1'b1;
    for (int i = 0; i < MAX_WIDTH_DEF * MAX_HEIGHT_DEF; i++) cell_mem[i] = BLANK_CELL;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_blank_reads();
    test_fill_cases();
    test_canvas_limits();
    test_random_traffic();

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d reads and %0d fills writing %0d cells",
             reads_issued, fills_issued, cells_filled);
    $display("over %0d canvas register writes, %0d mismatches", canvas_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS text_cell_rect_fill_core");
    end else begin
      $display("FAIL text_cell_rect_fill_core");
    end
    $finish;
  end

endmodule
